// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for clocked properties on clk, with or without rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/rc4fk_pkg.sv =====
// ----------------------------------------------------------------------------
// rc4fk_pkg
// Shared types and codes of the RC4 fixed keystream block.
// ----------------------------------------------------------------------------
package rc4fk_pkg;

  typedef logic [7:0] byte_t;

  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_DATA = 1'b1;

  // keystream memory write port driven by the scheduler
  typedef struct packed {
    logic  en;
    byte_t addr;
    byte_t data;
  } ks_wr_t;

endpackage

// ===== hdl/rc4fk_sched.sv =====
// ----------------------------------------------------------------------------
// rc4fk_sched
// Permutation fill and key schedule over the permutation memory, then the fixed keystream build.
// ----------------------------------------------------------------------------
module rc4fk_sched #(
  parameter int CW      = 9,
  parameter int KW      = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [CW-1:0]       key_len,
  output logic [KW-1:0]       key_raddr,
  input  rc4fk_pkg::byte_t    key_rdata,
  output rc4fk_pkg::ks_wr_t   ks_wr,
  output logic                done
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_INIT = 4'd1;
  localparam logic [3:0] K_RD   = 4'd2;
  localparam logic [3:0] K_J    = 4'd3;
  localparam logic [3:0] K_WI   = 4'd4;
  localparam logic [3:0] K_WJ   = 4'd5;
  localparam logic [3:0] G_RN   = 4'd6;
  localparam logic [3:0] G_RI   = 4'd7;
  localparam logic [3:0] G_RO   = 4'd8;
  localparam logic [3:0] G_W    = 4'd9;

  logic [3:0]       state;
  logic [3:0]       state_next;
  rc4fk_pkg::byte_t idx;
  rc4fk_pkg::byte_t j;
  rc4fk_pkg::byte_t si;
  rc4fk_pkg::byte_t sn;
  logic [KW-1:0]    k;
  logic [CW-1:0]    len;
  logic [CW-1:0]    k_inc;

  rc4fk_pkg::byte_t perm_mem [256];
  rc4fk_pkg::byte_t perm_rdata;
  rc4fk_pkg::byte_t raddr;
  rc4fk_pkg::byte_t waddr;
  rc4fk_pkg::byte_t wdata;
  rc4fk_pkg::byte_t j_new;
  rc4fk_pkg::byte_t n;
  logic             we;
  logic             idx_last;

  assign n        = idx + 8'd1;
  assign j_new    = j + perm_rdata + key_rdata;
  assign idx_last = (idx == 8'hFF);
  assign k_inc    = CW'(k) + CW'(1);
  assign key_raddr = k;

  always_comb begin
    state_next = state;
    raddr      = idx;
    we         = 1'b0;
    waddr      = idx;
    wdata      = idx;
    ks_wr.en   = 1'b0;
    ks_wr.addr = idx;
    ks_wr.data = perm_rdata;
    done       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_INIT;
      end
      S_INIT: begin
        we = 1'b1;
        if (idx_last) state_next = K_RD;
      end
      K_RD: begin
        state_next = K_J;
      end
      K_J: begin
        raddr      = j_new;
        state_next = K_WI;
      end
      K_WI: begin
        we         = 1'b1;
        wdata      = perm_rdata;
        state_next = K_WJ;
      end
      K_WJ: begin
        we         = 1'b1;
        waddr      = j;
        wdata      = si;
        state_next = idx_last ? G_RN : K_RD;
      end
      G_RN: begin
        raddr      = n;
        state_next = G_RI;
      end
      G_RI: begin
        raddr      = perm_rdata + n;
        state_next = G_RO;
      end
      G_RO: begin
        raddr      = sn + perm_rdata;
        state_next = G_W;
      end
      G_W: begin
        ks_wr.en = 1'b1;
        if (idx_last) begin
          done       = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = G_RN;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) perm_mem[waddr] <= wdata;
    perm_rdata <= perm_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      j     <= '0;
      k     <= '0;
      len   <= CW'(1);
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          idx <= '0;
          j   <= '0;
          k   <= '0;
          if (start) len <= key_len;
        end
        S_INIT: idx <= idx + 8'd1;
        K_J: j <= j_new;
        K_WJ: begin
          idx <= idx + 8'd1;
          k   <= (k_inc == len) ? '0 : k_inc[KW-1:0];
        end
        G_W: idx <= idx + 8'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == K_J) si <= perm_rdata;
    if (state == G_RI) sn <= perm_rdata;
  end

endmodule

// ===== hdl/rc4_fixed_keystream_xor.sv =====
// ----------------------------------------------------------------------------
// rc4_fixed_keystream_xor
// RC4 key schedule into a fixed 256-byte keystream XORed over data bytes.
// ----------------------------------------------------------------------------
// Data item: result registered in the cycle after accept; one data item per cycle
//   while no key schedule runs and the output is not stalled. The key item marked
//   key_last blocks input through the permutation fill, key schedule and keystream
//   build, limited by the single read port of the permutation memory.
// Reset clears control state only; memories keep contents.
module rc4_fixed_keystream_xor #(
  parameter int KEY_MAX = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             opcode,
  input  rc4fk_pkg::byte_t byte_value,
  input  logic             key_last,
  input  logic             buffer_start,
  output logic             out_valid,
  input  logic             out_ready,
  output rc4fk_pkg::byte_t plain_byte
);

  localparam int CW = $clog2(KEY_MAX + 1);
  localparam int KW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_SCHED = 1'b1;

  logic              state;
  logic [CW-1:0]     key_count;
  logic [CW-1:0]     count_after;
  logic              count_room;
  logic              keyed;
  rc4fk_pkg::byte_t  position;
  rc4fk_pkg::byte_t  rd_pos;
  logic              accept;
  logic              key_acc;
  logic              data_acc;
  logic              sched_start;
  logic              sched_done;

  rc4fk_pkg::byte_t  key_mem [KEY_MAX];
  rc4fk_pkg::byte_t  key_rdata;
  logic [KW-1:0]     key_raddr;

  rc4fk_pkg::byte_t  ks_mem [256];
  rc4fk_pkg::byte_t  ks_q;
  rc4fk_pkg::ks_wr_t ks_wr;

  rc4fk_pkg::byte_t  out_data;
  logic              out_keyed;

  assign in_ready    = (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept      = in_valid && in_ready;
  assign key_acc     = accept && (opcode == rc4fk_pkg::OP_KEY);
  assign data_acc    = accept && (opcode == rc4fk_pkg::OP_DATA);
  assign sched_start = key_acc && key_last;
  assign count_room  = (key_count < CW'(KEY_MAX));
  assign count_after = count_room ? key_count + CW'(1) : key_count;
  assign rd_pos      = buffer_start ? 8'h00 : position;
  assign plain_byte  = out_data ^ (out_keyed ? ks_q : 8'h00);

  rc4fk_sched #(
    .CW      (CW),
    .KW      (KW)
  ) u_sched (
    .clk       (clk),
    .rst       (rst),
    .start     (sched_start),
    .key_len   (count_after),
    .key_raddr (key_raddr),
    .key_rdata (key_rdata),
    .ks_wr     (ks_wr),
    .done      (sched_done)
  );

  always_ff @(posedge clk) begin
    if (key_acc && count_room) key_mem[key_count[KW-1:0]] <= byte_value;
    key_rdata <= key_mem[key_raddr];
  end

  always_ff @(posedge clk) begin
    if (ks_wr.en) ks_mem[ks_wr.addr] <= ks_wr.data;
    if (data_acc) ks_q <= ks_mem[rd_pos];
  end

  always_ff @(posedge clk) begin
    if (data_acc) begin
      out_data  <= byte_value;
      out_keyed <= keyed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      key_count <= '0;
      keyed     <= 1'b0;
      position  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (data_acc) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      if (data_acc) position <= rd_pos + 8'd1;

      unique case (state)
        ST_IDLE: begin
          if (sched_start) begin
            state     <= ST_SCHED;
            key_count <= '0;
            keyed     <= 1'b1;
            position  <= '0;
          end else if (key_acc) begin
            key_count <= count_after;
          end
        end
        ST_SCHED: begin
          if (sched_done) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/rc4fk_check.sv =====
// ----------------------------------------------------------------------------
// rc4fk_check
// Port-level checks of the RC4 fixed keystream block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rc4fk_check (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       opcode,
  input logic       key_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] plain_byte
);

  logic acc;
  logic data_acc;
  logic key_acc;
  logic out_free;
  logic out_stall;

  assign acc       = in_valid && in_ready;
  assign data_acc  = acc && (opcode == rc4fk_pkg::OP_DATA);
  assign key_acc   = acc && (opcode == rc4fk_pkg::OP_KEY);
  assign out_free  = !out_valid || out_ready;
  assign out_stall = out_valid && !out_ready;

  `ASSERT_CLK_ALWAYS(a_reset_empty, rst |=> !out_valid, "result shown after reset")
  `ASSERT_CLK(a_out_hold, out_stall |=> out_valid && $stable(plain_byte), "stalled result changed")
  `ASSERT_CLK(a_data_result, data_acc |=> out_valid, "data item gave no result")
  `ASSERT_CLK(a_key_silent, key_acc && out_free |=> !out_valid, "key item gave a result")
  `ASSERT_CLK(a_sched_busy, key_acc && key_last |=> !in_ready, "input open during key schedule")

endmodule

bind rc4_fixed_keystream_xor rc4fk_check u_rc4fk_check (.*);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rc4_fixed_keystream_xor. A short table of directed
// items covers pass-through before keying, ignored flags, a one-byte key and
// data during a partial key load. Random key loads (over-length and full
// length included) and data bursts follow. Every plain byte is compared with
// a table value or a local model of the key schedule and the fixed keystream.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEY_MAX      = 256;
  localparam int RANDOM_ITEMS = 1475;
  localparam int QUIET_TAIL   = 150;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 50;
  localparam int LIMIT_CYCLES = 1000000;

  typedef struct packed {
    logic             op;
    rc4fk_pkg::byte_t value;
    logic             last;
    logic             start;
    logic             known;
    rc4fk_pkg::byte_t plain;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  logic             opcode;
  rc4fk_pkg::byte_t byte_value;
  logic             key_last;
  logic             buffer_start;
  logic             out_valid;
  logic             out_ready;
  rc4fk_pkg::byte_t plain_byte;

  // model state
  rc4fk_pkg::byte_t key_mem    [KEY_MAX];
  int               key_len    = 0;
  rc4fk_pkg::byte_t perm_mem   [256];
  rc4fk_pkg::byte_t stream_mem [256];
  bit               keyed      = 1'b0;
  rc4fk_pkg::byte_t pos        = '0;

  rc4fk_pkg::byte_t expected_plain [$];
  dir_row_t         dir_rows       [$];

  int items_sent    = 0;
  int bytes_checked = 0;
  int schedules_run = 0;
  int error_count   = 0;
  int cycle_count   = 0;
  bit idle_on       = 1'b0;
  bit hold_req      = 1'b0;

  rc4_fixed_keystream_xor #(
    .KEY_MAX(KEY_MAX)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .byte_value  (byte_value),
    .key_last    (key_last),
    .buffer_start(buffer_start),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .plain_byte  (plain_byte)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic void predict_item(input logic op, input rc4fk_pkg::byte_t value,
                                       input logic last, input logic start,
                                       output bit produces,
                                       output rc4fk_pkg::byte_t plain);
    int               len;
    rc4fk_pkg::byte_t j;
    rc4fk_pkg::byte_t tmp;
    rc4fk_pkg::byte_t n;
    rc4fk_pkg::byte_t sn;
    rc4fk_pkg::byte_t inner;
    produces = 1'b0;
    plain    = value;
    if (op == rc4fk_pkg::OP_KEY) begin
      if (key_len < KEY_MAX) begin
        key_mem[key_len] = value;
        key_len++;
      end
      if (last) begin
        len = (key_len == 0) ? 1 : key_len;
        for (int i = 0; i < 256; i++) perm_mem[i] = rc4fk_pkg::byte_t'(i);
        j = '0;
        for (int i = 0; i < 256; i++) begin
          j           = j + perm_mem[i] + key_mem[i % len];
          tmp         = perm_mem[i];
          perm_mem[i] = perm_mem[j];
          perm_mem[j] = tmp;
        end
        for (int m = 0; m < 256; m++) begin
          n             = rc4fk_pkg::byte_t'(m + 1);
          sn            = perm_mem[n];
          inner         = perm_mem[rc4fk_pkg::byte_t'(sn + n)];
          stream_mem[m] = perm_mem[rc4fk_pkg::byte_t'(sn + inner)];
        end
        keyed   = 1'b1;
        key_len = 0;
        pos     = '0;
        schedules_run++;
      end
    end else begin
      if (start) pos = '0;
      if (keyed) plain = value ^ stream_mem[pos];
      pos      = pos + 8'd1;
      produces = 1'b1;
    end
  endfunction

  task automatic send_item(input logic op, input rc4fk_pkg::byte_t value, input logic last,
                           input logic start, input logic known,
                           input rc4fk_pkg::byte_t plain);
    bit               produces;
    rc4fk_pkg::byte_t predicted;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    byte_value   <= value;
    key_last     <= last;
    buffer_start <= start;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(op, value, last, start, produces, predicted);
    if (produces) expected_plain.push_back(known ? plain : predicted);
    items_sent++;
  endtask

  task automatic load_key(input int len);
    bit mix;
    mix = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < len; k++) begin
      send_item(rc4fk_pkg::OP_KEY, rc4fk_pkg::byte_t'($urandom_range(0, 255)), k == len - 1,
                1'($urandom_range(0, 1)), 1'b0, '0);
      // data while the new key is still incomplete
      if (mix && k != len - 1 && $urandom_range(0, 15) == 0)
        send_item(rc4fk_pkg::OP_DATA, rc4fk_pkg::byte_t'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0);
    end
  endtask

  task automatic data_burst(input int len);
    for (int k = 0; k < len; k++) begin
      send_item(rc4fk_pkg::OP_DATA, rc4fk_pkg::byte_t'($urandom_range(0, 255)),
                $urandom_range(0, 7) == 0,
                (k == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 31) == 0),
                1'b0, '0);
    end
  endtask

  function automatic void row(input logic op, input rc4fk_pkg::byte_t value,
                              input logic last, input logic start, input logic known,
                              input rc4fk_pkg::byte_t plain);
    dir_rows.push_back('{op, value, last, start, known, plain});
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_plain.size() == 0) begin
        $error("plain_byte: no item expected, got %02h", plain_byte);
        error_count++;
      end else begin
        if (plain_byte !== expected_plain[0]) begin
          $error("plain_byte: expected %02h, actual %02h", expected_plain[0], plain_byte);
          error_count++;
        end
        void'(expected_plain.pop_front());
        bytes_checked++;
      end
    end
  end

  initial begin : sink
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        for (int c = 0; c < LONG_HOLD; c++) @(posedge clk);
        out_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    wait (cycle_count >= LIMIT_CYCLES);
    $display("FAILURE");
    $finish;
  end

  initial begin : stim
    int keys_loaded;
    int start_count;
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    opcode       <= rc4fk_pkg::OP_DATA;
    byte_value   <= '0;
    key_last     <= 1'b0;
    buffer_start <= 1'b0;

    //  op                  value  last  start known plain
    row(rc4fk_pkg::OP_DATA, 8'h00, 1'b0, 1'b1, 1'b1, 8'h00);  // no key yet: pass-through
    row(rc4fk_pkg::OP_DATA, 8'hFF, 1'b1, 1'b0, 1'b1, 8'hFF);  // key_last ignored on data
    row(rc4fk_pkg::OP_DATA, 8'hA5, 1'b0, 1'b0, 1'b1, 8'hA5);
    row(rc4fk_pkg::OP_KEY,  8'h00, 1'b0, 1'b1, 1'b0, 8'h00);  // buffer_start ignored on key
    row(rc4fk_pkg::OP_DATA, 8'h5A, 1'b0, 1'b0, 1'b1, 8'h5A);  // key incomplete, still clear
    row(rc4fk_pkg::OP_KEY,  8'hFF, 1'b1, 1'b0, 1'b0, 8'h00);
    row(rc4fk_pkg::OP_DATA, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00);
    row(rc4fk_pkg::OP_DATA, 8'hFF, 1'b0, 1'b0, 1'b0, 8'h00);
    row(rc4fk_pkg::OP_DATA, 8'h3C, 1'b0, 1'b1, 1'b0, 8'h00);
    row(rc4fk_pkg::OP_DATA, 8'hC3, 1'b0, 1'b0, 1'b0, 8'h00);
    row(rc4fk_pkg::OP_KEY,  8'h01, 1'b1, 1'b0, 1'b0, 8'h00);  // one-byte key
    row(rc4fk_pkg::OP_DATA, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00);
    row(rc4fk_pkg::OP_DATA, 8'hFF, 1'b0, 1'b1, 1'b0, 8'h00);
    row(rc4fk_pkg::OP_KEY,  8'h80, 1'b0, 1'b1, 1'b0, 8'h00);
    row(rc4fk_pkg::OP_DATA, 8'h11, 1'b0, 1'b0, 1'b0, 8'h00);  // old keystream during load
    row(rc4fk_pkg::OP_DATA, 8'h22, 1'b1, 1'b1, 1'b0, 8'h00);
    row(rc4fk_pkg::OP_KEY,  8'h7F, 1'b1, 1'b0, 1'b0, 8'h00);
    row(rc4fk_pkg::OP_DATA, 8'h00, 1'b0, 1'b1, 1'b0, 8'h00);
    row(rc4fk_pkg::OP_DATA, 8'hFF, 1'b0, 1'b0, 1'b0, 8'h00);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r])
      send_item(dir_rows[r].op, dir_rows[r].value, dir_rows[r].last, dir_rows[r].start,
                dir_rows[r].known, dir_rows[r].plain);

    // long receiver hold-off while data keeps coming
    idle_on  = 1'b0;
    hold_req = 1'b1;
    data_burst(48);

    start_count = items_sent;
    keys_loaded = 0;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      idle_on = (RANDOM_ITEMS - (items_sent - start_count) > QUIET_TAIL) &&
                ($urandom_range(0, 3) != 0);
      if (keys_loaded < 2 || $urandom_range(0, 3) == 0) begin
        if (keys_loaded == 0)
          load_key($urandom_range(KEY_MAX + 1, KEY_MAX + 40));
        else if (keys_loaded == 1)
          load_key(KEY_MAX);
        else if ($urandom_range(0, 7) == 0)
          load_key($urandom_range(25, 80));
        else
          load_key($urandom_range(1, 24));
        keys_loaded++;
      end else begin
        data_burst($urandom_range(1, 48));
      end
    end
    data_burst(8);
    in_valid <= 1'b0;

    while (expected_plain.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d items: %0d plain bytes checked, %0d key schedules",
             items_sent, bytes_checked, schedules_run);
    if (error_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
